// File: hdl/vrpc_pkg.sv
// Package: shared types, codes and saturation helpers for the voice recorder core.
`default_nettype none

package vrpc_pkg;

  localparam int unsigned LenW = 17;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned DensityW = 8;

  localparam logic [4:0] RecShiftRst = 5'd11;
  localparam logic [3:0] PlayShiftRst = 4'd6;
  localparam logic [LenW-1:0] RecLenRst = 17'd40000;
  localparam logic [LenW-1:0] LenMax = 17'd65536;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REQ_PRESS  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REC_SHIFT  = 2'd0,
    CFG_PLAY_SHIFT = 2'd1,
    CFG_REC_LEN    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] mic_word;
  } in_req_t;

  typedef struct packed {
    logic signed [DensityW-1:0] density;
    logic                       density_valid;
    logic [1:0]                 mode;
    logic                       take_held;
  } out_req_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [31:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DensityW-1:0] sat8(input logic signed [SampleW-1:0] v);
    logic signed [DensityW-1:0] r;
    if (v > 16'sd127) begin
      r = 8'sh7f;
    end else if (v < -16'sd128) begin
      r = 8'sh80;
    end else begin
      r = v[DensityW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/voice_record_playback_controller_core.sv
// Top level: single-buffer voice record / playback controller with sample store.
//
// Takes one request per clock (press, microphone word or playback tick) and gives
// exactly one result per request. A result reaches the output register by way of stage 1:
// the accepting edge updates mode, position and take state, writes the sample store while
// recording and reads it for a tick; the edge that moves stage 1 into the result register
// scales and saturates the read sample into the density. The sample store is a
// single-port-per-side RAM of STORE_DEPTH 16-bit words with a registered read; its
// contents are undefined after reset and no clearing pass is run.
// The request side stalls only while the result register is full and stalled.
`default_nettype none

module voice_record_playback_controller_core
  import vrpc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_req_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_req_t                 out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LenCapInt =
    (STORE_DEPTH < (1 << LenW)) ? STORE_DEPTH : (1 << LenW) - 1;
  localparam logic [LenW-1:0] LenCap = LenW'(LenCapInt);

  // configuration
  logic [4:0]      rec_shift_r;
  logic [3:0]      play_shift_r;
  logic [LenW-1:0] rec_len_r;

  // control state
  mode_t           mode_r, mode_nxt;
  logic            take_r, take_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;

  // stage 1
  logic            p1_valid_r;
  logic            p1_smp_r, p1_smp_nxt;
  logic            p1_dval_r, p1_dval_nxt;
  mode_t           p1_mode_r;
  logic            p1_take_r;
  logic signed [SampleW-1:0] rd_data_r;

  // result register
  logic            out_valid_r;
  out_req_t        out_data_r;

  logic            accept;
  logic            adv2;
  logic [LenW-1:0] eff_len;
  logic [LenW-1:0] pos_inc;
  logic            wr_en;
  logic signed [SampleW-1:0] wr_data;
  logic signed [31:0] mic_shifted;
  logic signed [SampleW-1:0] smp_shifted;
  logic signed [DensityW-1:0] density_calc;
  logic [AddrW-1:0] mem_addr;

  logic signed [SampleW-1:0] store_mem [STORE_DEPTH];

  assign adv2     = p1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p1_valid_r && !adv2;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (rec_len_r == '0) begin
      eff_len = LenW'(1);
    end else if (rec_len_r > LenCap) begin
      eff_len = LenCap;
    end else begin
      eff_len = rec_len_r;
    end
  end

  assign pos_inc     = pos_r + LenW'(1);
  assign mem_addr    = AddrW'(pos_r);
  assign mic_shifted = in_data.mic_word >>> rec_shift_r;
  assign wr_data     = sat16(mic_shifted);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    take_nxt = take_r;
    pos_nxt  = pos_r;
    case (req_code_t'(in_data.req_type))
      REQ_PRESS: begin
        if (mode_r == MODE_IDLE) begin
          pos_nxt  = '0;
          mode_nxt = take_r ? MODE_PLAY : MODE_REC;
        end
      end
      REQ_SAMPLE: begin
        if (mode_r == MODE_REC) begin
          pos_nxt = pos_inc;
          if (pos_inc >= eff_len) begin
            take_nxt = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
      end
      REQ_TICK: begin
        if (mode_r == MODE_PLAY) begin
          if (pos_r >= eff_len) begin
            take_nxt = 1'b0;
            mode_nxt = MODE_IDLE;
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // per-request outputs
  always_comb begin
    wr_en       = 1'b0;
    p1_smp_nxt  = 1'b0;
    p1_dval_nxt = 1'b0;
    case (req_code_t'(in_data.req_type))
      REQ_SAMPLE: begin
        wr_en = (mode_r == MODE_REC) && (pos_r < LenCap);
      end
      REQ_TICK: begin
        if (mode_r == MODE_PLAY) begin
          p1_dval_nxt = 1'b1;
          p1_smp_nxt  = (pos_r < eff_len);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_shift_r  <= RecShiftRst;
      play_shift_r <= PlayShiftRst;
      rec_len_r    <= RecLenRst;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REC_SHIFT:  rec_shift_r  <= cfg_wdata[4:0];
        CFG_PLAY_SHIFT: play_shift_r <= cfg_wdata[3:0];
        CFG_REC_LEN:    rec_len_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      take_r     <= 1'b0;
      pos_r      <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r     <= mode_nxt;
        take_r     <= take_nxt;
        pos_r      <= pos_nxt;
        p1_valid_r <= 1'b1;
      end else if (adv2) begin
        p1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_smp_r  <= p1_smp_nxt;
      p1_dval_r <= p1_dval_nxt;
      p1_mode_r <= mode_nxt;
      p1_take_r <= take_nxt;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store_mem[mem_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= store_mem[mem_addr];
    end
  end

  // density stage
  assign smp_shifted  = rd_data_r >>> play_shift_r;
  assign density_calc = p1_smp_r ? sat8(smp_shifted) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_data_r.density       <= density_calc;
      out_data_r.density_valid <= p1_dval_r;
      out_data_r.mode          <= p1_mode_r;
      out_data_r.take_held     <= p1_take_r;
    end
  end

  a_play_has_take: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PLAY) |-> take_r)
    else $error("playing without a held take");

  a_rec_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_REC) |-> !take_r)
    else $error("recording while a take is held");

  a_out_play_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.mode == MODE_PLAY) |-> out_data_r.take_held)
    else $error("result shows playback without a take");

  a_silent_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.density_valid) |-> (out_data_r.density == '0))
    else $error("density nonzero without update");

  a_stall_needs_p1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (p1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: tb/sv/voice_playback_checker.sv
`timescale 1ns / 100ps
// Checker: mirrors the recorder state, predicts each result and compares it field by field.
module voice_playback_checker
  import vrpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire in_req_t             in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire out_req_t            out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending
);

  localparam int unsigned Depth = 65536;

  logic [4:0]         rec_shift;
  logic [3:0]         play_shift;
  logic [LenW-1:0]    rec_len;
  mode_t              now_mode;
  logic               holding;
  logic [LenW-1:0]    pos;
  logic signed [15:0] take_mem [Depth];
  out_req_t           due_q [$];

  task automatic advance_recorder(input in_req_t r, output out_req_t res);
    int unsigned        lim;
    logic signed [31:0] scaled;
    logic signed [15:0] smp;
    logic signed [15:0] sh;
    lim = (rec_len == 0) ? 1 : ((rec_len > Depth) ? Depth : rec_len);
    res = '0;
    case (req_code_t'(r.req_type))
      REQ_PRESS: begin
        if (now_mode == MODE_IDLE) begin
          pos = '0;
          now_mode = holding ? MODE_PLAY : MODE_REC;
        end
      end
      REQ_SAMPLE: begin
        if (now_mode == MODE_REC) begin
          scaled = $signed(r.mic_word) >>> rec_shift;
          if (scaled > 32'sd32767) begin
            take_mem[pos[15:0]] = 16'sh7fff;
          end else if (scaled < -32'sd32768) begin
            take_mem[pos[15:0]] = 16'sh8000;
          end else begin
            take_mem[pos[15:0]] = scaled[15:0];
          end
          pos = pos + 1'b1;
          if (pos >= lim) begin
            holding = 1'b1;
            now_mode = MODE_IDLE;
          end
        end
      end
      REQ_TICK: begin
        if (now_mode == MODE_PLAY) begin
          res.density_valid = 1'b1;
          if (pos >= lim) begin
            holding = 1'b0;
            now_mode = MODE_IDLE;
          end else begin
            smp = take_mem[pos[15:0]];
            sh = smp >>> play_shift;
            if (sh > 16'sd127) begin
              res.density = 8'sh7f;
            end else if (sh < -16'sd128) begin
              res.density = 8'sh80;
            end else begin
              res.density = sh[7:0];
            end
            pos = pos + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.mode = now_mode;
    res.take_held = holding;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_req_t want;
    out_req_t next_res;
    if (!rst_n) begin
      rec_shift = RecShiftRst;
      play_shift = PlayShiftRst;
      rec_len = RecLenRst;
      now_mode = MODE_IDLE;
      holding = 1'b0;
      pos = '0;
      due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REC_SHIFT:  rec_shift = cfg_wdata[4:0];
          CFG_PLAY_SHIFT: play_shift = cfg_wdata[3:0];
          CFG_REC_LEN:    rec_len = cfg_wdata[LenW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("result with no request outstanding: density %0d mode %0d",
                 $signed(out_data.density), out_data.mode);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          check_field("density", $signed(want.density), $signed(out_data.density));
          check_field("density_valid", want.density_valid, out_data.density_valid);
          check_field("mode", want.mode, out_data.mode);
          check_field("take_held", want.take_held, out_data.take_held);
        end
      end
      if (in_valid && !in_stall) begin
        advance_recorder(in_data, next_res);
        due_q.push_back(next_res);
      end
    end
    pending = due_q.size();
  end

endmodule

// File: tb/sv/voice_record_playback_controller_core_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives requests, register writes and result back-pressure, gives the verdict.
module voice_record_playback_controller_core_tb;
  import vrpc_pkg::*;

  localparam int unsigned Depth = 65536;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_req_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_req_t            out_data;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int                  fail_count;
  int                  pending;

  logic        quiet = 1'b0;
  logic        out_took = 1'b0;
  int unsigned out_hold = 0;
  int unsigned take_len = 40000;
  int unsigned take_count = 0;
  int unsigned req_count = 0;
  int unsigned stop_at;

  always #5 clk = ~clk;

  voice_record_playback_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  voice_playback_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random stall after each accepted result
  always @(posedge clk) begin
    out_took <= rst_n && out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_took) begin
      out_hold = quiet ? 0 : $urandom_range(0, 16);
    end
    if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input req_code_t kind, input logic [31:0] word);
    in_req_t     r;
    int unsigned gap;
    r.req_type = kind;
    r.mic_word = word;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    req_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    if (idx == CFG_REC_LEN) begin
      take_len = (value[LenW-1:0] == 0) ? 1 :
                 ((value[LenW-1:0] > Depth) ? Depth : value[LenW-1:0]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] mic_pick();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h7fff_ffff;
      1: w = 32'h8000_0000;
      2: w = $urandom >> $urandom_range(0, 31);
      3: w = ~($urandom >> $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // a request that the given mode leaves without effect
  task automatic ignored_req(input mode_t m);
    req_code_t kind;
    req_code_t live;
    if (m == MODE_IDLE) begin
      live = REQ_PRESS;
    end else if (m == MODE_REC) begin
      live = REQ_SAMPLE;
    end else begin
      live = REQ_TICK;
    end
    do kind = req_code_t'($urandom_range(0, 3)); while (kind == live);
    send(kind, $urandom);
  endtask

  task automatic record_take(input int unsigned noise_pct, input bit cut);
    int unsigned n;
    int unsigned need;
    int unsigned cut_at;
    send(REQ_PRESS, $urandom);
    n = 0;
    need = take_len;
    cut = cut && (take_len > 1);
    cut_at = (take_len > 1) ? $urandom_range(1, take_len - 1) : 0;
    while (n < need) begin
      if ($urandom_range(0, 99) < noise_pct) ignored_req(MODE_REC);
      if (cut && n == cut_at) begin
        drain();
        set_reg(CFG_REC_LEN, $urandom_range(0, 2 * take_len));
        need = (take_len > n + 1) ? take_len : n + 1;
        cut = 1'b0;
      end
      send(REQ_SAMPLE, mic_pick());
      n++;
    end
    take_count = n;
  endtask

  task automatic play_take(input int unsigned noise_pct, input bit cut);
    int unsigned ticks;
    int unsigned need;
    int unsigned cut_at;
    send(REQ_PRESS, $urandom);
    ticks = 0;
    need = take_len + 1;
    cut_at = $urandom_range(0, take_len);
    while (ticks < need) begin
      if ($urandom_range(0, 99) < noise_pct) ignored_req(MODE_PLAY);
      if (cut && ticks == cut_at) begin
        // length may only move within what the take wrote
        drain();
        set_reg(CFG_REC_LEN, $urandom_range(0, take_count));
        need = ticks + 1 + ((take_len > ticks) ? take_len - ticks : 0);
        cut = 1'b0;
      end
      send(REQ_TICK, $urandom);
      ticks++;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle: samples, ticks and the unused code change nothing
    send(REQ_TICK, 32'h0000_0000);
    send(REQ_SAMPLE, 32'h7fff_ffff);
    send(REQ_NONE, 32'hffff_ffff);

    // zero length acts as one; shifts still at reset values
    drain();
    set_reg(CFG_REC_LEN, 0);
    set_reg(CFG_UNUSED, 17'h1ffff);
    send(REQ_PRESS, 32'h0);
    send(REQ_SAMPLE, 32'h7fff_ffff);
    send(REQ_PRESS, 32'h0);
    send(REQ_TICK, 32'h0);
    send(REQ_TICK, 32'h0);

    drain();
    set_reg(CFG_REC_SHIFT, 0);
    set_reg(CFG_PLAY_SHIFT, 0);
    set_reg(CFG_REC_LEN, 2);
    send(REQ_PRESS, 32'h0);
    send(REQ_SAMPLE, 32'h8000_0000);
    send(REQ_TICK, 32'h0);
    send(REQ_SAMPLE, 32'h0000_0064);
    send(REQ_PRESS, 32'h0);
    send(REQ_PRESS, 32'h0);
    send(REQ_SAMPLE, 32'h7fff_ffff);
    send(REQ_TICK, 32'h0);
    send(REQ_TICK, 32'h0);
    send(REQ_TICK, 32'h0);

    // record shift past the sample width, play shift at its largest; length shrinks mid-record, grows mid-play
    drain();
    set_reg(CFG_REC_SHIFT, 31);
    set_reg(CFG_PLAY_SHIFT, 15);
    set_reg(CFG_REC_LEN, 4);
    send(REQ_PRESS, 32'h0);
    send(REQ_SAMPLE, 32'h8000_0000);
    send(REQ_SAMPLE, 32'h7fff_ffff);
    drain();
    set_reg(CFG_REC_LEN, 1);
    send(REQ_SAMPLE, 32'hffff_ffff);
    send(REQ_PRESS, 32'h0);
    send(REQ_TICK, 32'h0);
    drain();
    set_reg(CFG_REC_LEN, 2);
    send(REQ_TICK, 32'h0);
    send(REQ_TICK, 32'h0);

    stop_at = req_count + 950;
    while (req_count < stop_at) begin
      drain();
      set_reg(CFG_REC_SHIFT, $urandom_range(0, 31));
      set_reg(CFG_PLAY_SHIFT, $urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0: set_reg(CFG_REC_LEN, 0);
        1: set_reg(CFG_REC_LEN, 1);
        2, 3: set_reg(CFG_REC_LEN, $urandom_range(25, 64));
        default: set_reg(CFG_REC_LEN, $urandom_range(2, 24));
      endcase
      quiet <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 3)) ignored_req(MODE_IDLE);
      record_take($urandom_range(0, 30), $urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 3)) ignored_req(MODE_IDLE);
      if ($urandom_range(0, 3) == 0) drain();
      play_take($urandom_range(0, 30), $urandom_range(0, 3) == 0);
    end

    // length above the store, cut back after a few words; no idling on either side
    drain();
    set_reg(CFG_REC_SHIFT, $urandom_range(0, 24));
    set_reg(CFG_PLAY_SHIFT, $urandom_range(0, 15));
    set_reg(CFG_REC_LEN, 17'h1ffff);
    quiet <= 1'b1;
    send(REQ_PRESS, 32'h0);
    repeat (16) send(REQ_SAMPLE, mic_pick());
    drain();
    set_reg(CFG_REC_LEN, 17);
    send(REQ_SAMPLE, mic_pick());
    take_count = 17;
    play_take(0, 1'b0);
    quiet <= 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/vrpc_pkg.sv
hdl/voice_record_playback_controller_core.sv
tb/sv/voice_playback_checker.sv
tb/sv/voice_record_playback_controller_core_tb.sv
